FILE: rtl/bitmap_video_colour_plotter_defines.svh
// ----------------------------------------------------------------------------
// bitmap video colour plotter - assertion macros
// shared check macros, sampled on clock and disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef BITMAP_VIDEO_COLOUR_PLOTTER_DEFINES_SVH
`define BITMAP_VIDEO_COLOUR_PLOTTER_DEFINES_SVH

// same-cycle implication
`define BVCP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BVCP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/bvcp_pkg.sv
// ----------------------------------------------------------------------------
// bvcp_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bvcp_pkg;

   // storage sizes
   localparam int VIDEO_DEPTH = 8192;
   localparam int PROM_DEPTH  = 1024;
   localparam int VA_W        = $clog2(VIDEO_DEPTH);
   localparam int PA_W        = $clog2(PROM_DEPTH);

   // field widths
   localparam int OP_W    = 2;
   localparam int ADDR_W  = 13;
   localparam int VAL_W   = 8;
   localparam int COORD_W = 8;
   localparam int PEN_W   = 4;
   localparam int BASE_W  = 12;
   localparam int IDX_W   = 14;   // colour base plus cell offset, or a raw load address
   localparam int PIX_W   = 3;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_VIDEO  = 2'd0;
   localparam logic [OP_W-1:0] OP_COLOUR = 2'd1;
   localparam logic [OP_W-1:0] OP_PROM   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VARIANT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR_X = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR_Y = 2'd3;

   // machine variants
   localparam logic [1:0] VARIANT_NIBBLE = 2'd1;
   localparam logic [1:0] VARIANT_CELL16 = 2'd2;
   localparam logic [1:0] VARIANT_BANK   = 2'd3;

   // colour register numbers
   localparam logic [1:0] CREG_0 = 2'd0;
   localparam logic [1:0] CREG_1 = 2'd1;
   localparam logic [1:0] CREG_2 = 2'd2;
   localparam int         NUM_CREGS = 3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_VCMP,
      ST_PEN_REDUCE,
      ST_LOAD_REDUCE,
      ST_PREAD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic clear_wr;
      logic vid_rd;
      logic vid_wr;
      logic colour_wr;
      logic idx_load_addr;
      logic idx_load_pen;
      logic idx_reduce;
      logic prom_rd;
      logic prom_wr;
      logic pen_load;
      logic pix_next;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            addr_in_range;
      logic            byte_differs;
      logic            idx_over;
      logic            pix_last;
      logic            clear_last;
   } status_type;

endpackage

FILE: rtl/bitmap_video_colour_plotter.sv
// ----------------------------------------------------------------------------
// bitmap_video_colour_plotter
// 1 bpp video store writes turned into coloured, oriented pixel beats
// ----------------------------------------------------------------------------
// usage
//   req channel: one beat per cpu-side write (video byte, colour register or
//     colour prom load); req_tready is high only while the block is idle
//   rsp channel: eight pixel beats per video write whose byte changed, bit 0
//     first; rsp_tlast marks the eighth
//   csr port: machine variant, axis swap and mirrors, written while idle
// sequencing
//   colour register write: applied from the captured beat, then back to ready
//   prom load: one compare-subtract per cycle folds the index, then the entry is written
//   unchanged or out-of-range video write: no pixel beat, straight back to ready
//   changed video write: store read, compare, index fold and prom read come
//     before the first pixel, then one pixel per cycle while rsp_tready is high;
//     no new write is taken until the eighth pixel is taken
// reset
//   after reset the video store is swept to zero, one entry per cycle, all
//   VIDEO_DEPTH entries (8192 as built); no beat is taken meanwhile
// stall
//   a low rsp_tready holds the current pixel; the walk resumes where it stopped
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitmap_video_colour_plotter_defines.svh"

module bitmap_video_colour_plotter (
   input  logic                                clock,
   input  logic                                reset,
   // address [12:0], value [20:13], zero [23:21]
   input  logic [23:0]                         req_tdata,
   // operation [1:0]
   input  logic [bvcp_pkg::OP_W-1:0]           req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pixel_row [7:0], pixel_col [15:8], pen [19:16], lit [20], zero [23:21]
   output logic [23:0]                         rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [bvcp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bvcp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import bvcp_pkg::*;

   cmd_type              cmd;
   status_type           st;
   logic [COORD_W-1:0]   pixel_row;
   logic [COORD_W-1:0]   pixel_col;
   logic [PEN_W-1:0]     pen;
   logic                 lit;

   // sequencer
   bvcp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .st         (st),
      .cmd        (cmd)
   );

   // storage, colour lookup and coordinate walk
   bvcp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .operation  (req_tuser),
      .address    (req_tdata[12:0]),
      .value      (req_tdata[20:13]),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .pixel_row  (pixel_row),
      .pixel_col  (pixel_col),
      .pen        (pen),
      .lit        (lit),
      .last_pixel (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, lit, pen, pixel_col, pixel_row};

   // one write in flight: never ready while pixels are pending
   `BVCP_ASSERT_NOW(a_ready_excl_valid, rsp_tvalid, !req_tready, "ready while pixels pending")
   // the walk ends after the tagged eighth pixel
   `BVCP_ASSERT_NEXT(a_idle_after_last, rsp_tvalid && rsp_tready && rsp_tlast, req_tready,
      "not idle after last pixel")
   // prom is only read or written once the index is folded below its depth
   `BVCP_ASSERT_NOW(a_prom_idx_folded, cmd.prom_rd || cmd.prom_wr, !st.idx_over,
      "prom accessed with unfolded index")
   // no request is taken and no pixel is offered during the clearing sweep
   `BVCP_ASSERT_NOW(a_no_req_in_clear, cmd.clear_wr, !req_tready && !rsp_tvalid,
      "handshake during store clear")

endmodule

FILE: rtl/bvcp_ram.sv
// ----------------------------------------------------------------------------
// bvcp_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bvcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/bvcp_datapath.sv
// ----------------------------------------------------------------------------
// bvcp_datapath
// video store, colour prom, colour registers, index folding and pixel walk
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bvcp_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  bvcp_pkg::cmd_type                  cmd,
   output bvcp_pkg::status_type               st,
   input  logic [bvcp_pkg::OP_W-1:0]          operation,
   input  logic [bvcp_pkg::ADDR_W-1:0]        address,
   input  logic [bvcp_pkg::VAL_W-1:0]         value,
   input  logic                               csr_we,
   input  logic [bvcp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bvcp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic [bvcp_pkg::COORD_W-1:0]       pixel_row,
   output logic [bvcp_pkg::COORD_W-1:0]       pixel_col,
   output logic [bvcp_pkg::PEN_W-1:0]         pen,
   output logic                               lit,
   output logic                               last_pixel
);

   import bvcp_pkg::*;

   // configuration
   logic [1:0] variant_ff, variant_in;
   logic       swap_ff, swap_in;
   logic       mx_ff, mx_in;
   logic       my_ff, my_in;

   // colour state
   logic [VAL_W-1:0]  creg0_ff, creg0_in;
   logic [VAL_W-1:0]  creg1_ff, creg1_in;
   logic [VAL_W-1:0]  creg2_ff, creg2_in;
   logic [BASE_W-1:0] base_ff, base_in;

   // captured beat and work registers
   logic [OP_W-1:0]   op_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [VAL_W-1:0]  value_ff;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [PEN_W-1:0]  pen_ff, pen_in;
   logic [PIX_W-1:0]  pix_ff, pix_in;
   logic [VA_W-1:0]   clear_cnt_ff, clear_cnt_in;

   logic              is_cell16, is_bank;
   logic [COORD_W-1:0] sx, sy, a, b, w;
   logic              flip_a, walk_up, band;
   logic [8:0]        cell_off;
   logic [IDX_W-1:0]  pen_idx;
   logic              bit_now;

   logic              vid_we;
   logic [VA_W-1:0]   vid_waddr;
   logic [VAL_W-1:0]  vid_wdata;
   logic [VAL_W-1:0]  vid_rdata;
   logic [VAL_W-1:0]  prom_rdata;

   assign is_cell16 = (variant_ff == VARIANT_CELL16);
   assign is_bank   = (variant_ff == VARIANT_BANK);

   // screen position of the strip
   assign sx = addr_ff[ADDR_W-1:5];
   assign sy = {~addr_ff[4:0], 3'b000};

   // prom cell offset; row term 15 - sy/16 equals addr[4:1]
   assign band = (sy > 8'd23) && (sy < 8'd32);
   always_comb begin
      if (is_cell16) begin
         cell_off = {1'b0, sx[7:4], (band ? 4'd13 : addr_ff[4:1])};
      end else begin
         cell_off = {addr_ff[4:1], sx[7:3]};
      end
   end
   assign pen_idx = {2'b00, base_ff} + {5'b00000, cell_off};

   // configuration writes
   always_comb begin
      variant_in = variant_ff;
      swap_in    = swap_ff;
      mx_in      = mx_ff;
      my_in      = my_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_VARIANT:  variant_in = csr_wdata;
            CSR_SWAP:     swap_in    = csr_wdata[0];
            CSR_MIRROR_X: mx_in      = csr_wdata[0];
            CSR_MIRROR_Y: my_in      = csr_wdata[0];
            default:      variant_in = variant_ff;
         endcase
      end
   end

   // colour register writes and bank base
   always_comb begin
      creg0_in = creg0_ff;
      creg1_in = creg1_ff;
      creg2_in = creg2_ff;
      base_in  = base_ff;
      if (cmd.colour_wr) begin
         if (!is_cell16 && !is_bank) begin
            creg1_in = value_ff;
         end else if (addr_ff < ADDR_W'(NUM_CREGS)) begin
            case (addr_ff[1:0])
               CREG_0:  creg0_in = value_ff;
               CREG_1:  creg1_in = value_ff;
               CREG_2:  creg2_in = value_ff;
               default: creg0_in = creg0_ff;
            endcase
            if (is_bank) begin
               base_in = {2'b00, creg0_in, 2'b00} + {1'b0, creg2_in, 3'b000};
            end else begin
               base_in = ((creg0_in == 8'd1) ? 12'h100 : 12'h000)
                       + ((creg1_in == 8'd1) ? 12'h200 : 12'h000);
            end
         end
      end
   end

   // prom index load and fold
   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_load_addr) begin
         idx_in = {1'b0, addr_ff};
      end else if (cmd.idx_load_pen) begin
         idx_in = pen_idx;
      end else if (cmd.idx_reduce) begin
         idx_in = idx_ff - IDX_W'(PROM_DEPTH);
      end
   end

   always_comb begin
      pen_in = pen_ff;
      if (cmd.pen_load) begin
         if (!is_cell16 && (creg1_ff != 8'd0)) begin
            pen_in = prom_rdata[7:4];
         end else begin
            pen_in = prom_rdata[3:0];
         end
      end
   end

   always_comb begin
      pix_in = pix_ff;
      if (cmd.pen_load) begin
         pix_in = '0;
      end else if (cmd.pix_next) begin
         pix_in = pix_ff + PIX_W'(1);
      end
   end

   assign clear_cnt_in = cmd.clear_wr ? clear_cnt_ff + VA_W'(1) : clear_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff   <= VARIANT_NIBBLE;
         swap_ff      <= 1'b0;
         mx_ff        <= 1'b0;
         my_ff        <= 1'b0;
         creg0_ff     <= '0;
         creg1_ff     <= '0;
         creg2_ff     <= '0;
         base_ff      <= '0;
         clear_cnt_ff <= '0;
      end else begin
         variant_ff   <= variant_in;
         swap_ff      <= swap_in;
         mx_ff        <= mx_in;
         my_ff        <= my_in;
         creg0_ff     <= creg0_in;
         creg1_ff     <= creg1_in;
         creg2_ff     <= creg2_in;
         base_ff      <= base_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= operation;
         addr_ff  <= address;
         value_ff <= value;
      end
      idx_ff <= idx_in;
      pen_ff <= pen_in;
      pix_ff <= pix_in;
   end

   // video store, cleared by a sweep after reset
   assign vid_we    = cmd.clear_wr | cmd.vid_wr;
   assign vid_waddr = cmd.clear_wr ? clear_cnt_ff : addr_ff[VA_W-1:0];
   assign vid_wdata = cmd.clear_wr ? '0 : value_ff;

   bvcp_ram #(
      .WIDTH (VAL_W),
      .DEPTH (VIDEO_DEPTH)
   ) u_video_ram (
      .clock (clock),
      .we    (vid_we),
      .waddr (vid_waddr),
      .wdata (vid_wdata),
      .re    (cmd.vid_rd),
      .raddr (addr_ff[VA_W-1:0]),
      .rdata (vid_rdata)
   );

   bvcp_ram #(
      .WIDTH (VAL_W),
      .DEPTH (PROM_DEPTH)
   ) u_colour_prom (
      .clock (clock),
      .we    (cmd.prom_wr),
      .waddr (idx_ff[PA_W-1:0]),
      .wdata (value_ff),
      .re    (cmd.prom_rd),
      .raddr (idx_ff[PA_W-1:0]),
      .rdata (prom_rdata)
   );

   // orientation
   assign flip_a  = swap_ff ? !mx_ff : mx_ff;
   assign walk_up = swap_ff ? my_ff : !my_ff;
   assign a       = flip_a ? 8'd192 - sx : sx;
   assign b       = walk_up ? sy : 8'd255 - sy;
   assign w       = walk_up ? b + {5'b00000, pix_ff} : b - {5'b00000, pix_ff};
   assign bit_now = value_ff[pix_ff];

   assign pixel_row  = swap_ff ? a : w;
   assign pixel_col  = swap_ff ? w : a;
   assign pen        = bit_now ? pen_ff : '0;
   assign lit        = bit_now;
   assign last_pixel = (pix_ff == PIX_W'(7));

   assign st.op            = op_ff;
   assign st.addr_in_range = ({1'b0, addr_ff} < (ADDR_W + 1)'(VIDEO_DEPTH));
   assign st.byte_differs  = (vid_rdata != value_ff);
   assign st.idx_over      = (idx_ff >= IDX_W'(PROM_DEPTH));
   assign st.pix_last      = last_pixel;
   assign st.clear_last    = (clear_cnt_ff == VA_W'(VIDEO_DEPTH - 1));

endmodule

FILE: rtl/bvcp_ctrl.sv
// ----------------------------------------------------------------------------
// bvcp_ctrl
// sequencer: store clear, request decode, index folding and pixel beats
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bvcp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  bvcp_pkg::status_type st,
   output bvcp_pkg::cmd_type    cmd
);

   import bvcp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (st.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (st.op == OP_VIDEO && st.addr_in_range) begin
               state_in = ST_VCMP;
            end else if (st.op == OP_PROM) begin
               state_in = ST_LOAD_REDUCE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_VCMP: begin
            state_in = st.byte_differs ? ST_PEN_REDUCE : ST_IDLE;
         end
         ST_PEN_REDUCE: begin
            if (!st.idx_over) state_in = ST_PREAD;
         end
         ST_LOAD_REDUCE: begin
            if (!st.idx_over) state_in = ST_IDLE;
         end
         ST_PREAD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_tready && st.pix_last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_DECODE: begin
            cmd.vid_rd        = (st.op == OP_VIDEO) && st.addr_in_range;
            cmd.colour_wr     = (st.op == OP_COLOUR);
            cmd.idx_load_addr = (st.op == OP_PROM);
         end
         ST_VCMP: begin
            cmd.vid_wr       = st.byte_differs;
            cmd.idx_load_pen = st.byte_differs;
         end
         ST_PEN_REDUCE: begin
            cmd.idx_reduce = st.idx_over;
            cmd.prom_rd    = !st.idx_over;
         end
         ST_LOAD_REDUCE: begin
            cmd.idx_reduce = st.idx_over;
            cmd.prom_wr    = !st.idx_over;
         end
         ST_PREAD: begin
            cmd.pen_load = 1'b1;
         end
         ST_EMIT: begin
            rsp_tvalid   = 1'b1;
            cmd.pix_next = rsp_tready;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - bitmap video colour plotter testbench
// cpu write beats go in from a queue; every pixel beat that comes out is
// checked against a cycle-free prediction of the plotter, in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   import bvcp_pkg::*;

   // codes the package leaves unnamed
   localparam logic [OP_W-1:0] OP_NONE      = 2'd3;
   localparam logic [1:0]      VARIANT_ZERO = 2'd0;

   localparam int WATCHDOG_LIMIT = 40000;   // several times the clearing sweep after reset
   localparam int SETTLE_CYCLES  = 24;      // longest prom load fold plus margin

   // one cpu write beat; op travels on req_tuser, the rest on req_tdata
   typedef struct packed {
      logic [VAL_W-1:0]  value;
      logic [ADDR_W-1:0] addr;
      logic [OP_W-1:0]   op;
   } cpu_write_type;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [PEN_W-1:0]   pen;
      logic               lit;
      logic               last;
   } pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [23:0] req_tdata = '0;      // address [12:0], value [20:13], zero [23:21]
   logic [OP_W-1:0] req_tuser = '0;  // operation [1:0]
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] rsp_tdata;           // pixel_row [7:0], pixel_col [15:8], pen [19:16], lit [20]
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bitmap_video_colour_plotter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // shadow of the plotter: stores, colour registers and settings
   // ---------------------------------------------------------------------
   logic [VAL_W-1:0]  video_shadow [VIDEO_DEPTH];
   logic [VAL_W-1:0]  colour_table [PROM_DEPTH];
   bit                prom_loaded [PROM_DEPTH];
   logic [VAL_W-1:0]  colour_reg [NUM_CREGS];
   logic [BASE_W-1:0] colour_base;
   logic [1:0]        cfg_variant;
   logic              cfg_swap;
   logic              cfg_mirror_x;
   logic              cfg_mirror_y;

   cpu_write_type cpu_writes [$];       // beats waiting for the driver
   pixel_type     pending_pixels [$];   // predicted pixel beats, oldest first

   int  issued_count   = 0;
   int  accepted_count = 0;
   int  error_count    = 0;
   int  idle_cycles    = 0;
   int  send_gap       = 0;
   int  stall_left     = 0;
   bit  steady_flow    = 1'b0;       // no idling on either side while set
   bit  req_took       = 1'b0;
   bit  rsp_took       = 1'b0;
   cpu_write_type next_write;
   pixel_type     got_pixel;
   pixel_type     want_pixel;

   // colour prom index a video offset looks up, before the depth wrap
   function automatic int lookup_index(input logic [ADDR_W-1:0] addr);
      int sx;
      int sy;
      sx = int'(addr) / 32;
      sy = 248 - 8 * (int'(addr) % 32);
      // 8x16 cells
      if (cfg_variant != VARIANT_CELL16) return int'(colour_base) + (15 - sy / 16) * 32 + sx / 8;
      // 16x16 cells, rows 24-31 share one special entry per cell column
      if (sy > 23 && sy < 32) return int'(colour_base) + (sx / 16) * 16 + 13;
      return int'(colour_base) + (sx / 16) * 16 + (15 - sy / 16);
   endfunction

   // predicted effect of one cpu write; beats are taken in queue order
   task automatic apply_cpu_write(input cpu_write_type w);
      int         sx;
      int         sy;
      int         idx;
      int         fixed_coord;
      int         walk_start;
      int         walk;
      logic       walk_up;
      logic       lit;
      logic [7:0] table_byte;
      logic [3:0] pen;
      pixel_type  px;
      case (w.op)
         OP_COLOUR: begin
            if (cfg_variant != VARIANT_CELL16 && cfg_variant != VARIANT_BANK) begin
               // nibble-select machines: any register number lands in register 1
               colour_reg[CREG_1] = w.value;
            end else if (w.addr <= CREG_2) begin
               colour_reg[w.addr[1:0]] = w.value;
               if (cfg_variant == VARIANT_BANK) begin
                  colour_base = BASE_W'((int'(colour_reg[CREG_0]) << 2)
                                        + (int'(colour_reg[CREG_2]) << 3));
               end else begin
                  colour_base = '0;
                  if (colour_reg[CREG_0] == 8'd1) colour_base = colour_base + 12'h100;
                  if (colour_reg[CREG_1] == 8'd1) colour_base = colour_base + 12'h200;
               end
            end
         end
         OP_PROM: begin
            colour_table[int'(w.addr) % PROM_DEPTH] = w.value;
            prom_loaded[int'(w.addr) % PROM_DEPTH]  = 1'b1;
         end
         OP_VIDEO: begin
            if (int'(w.addr) < VIDEO_DEPTH && video_shadow[w.addr] != w.value) begin
               video_shadow[w.addr] = w.value;
               sx = int'(w.addr) / 32;
               sy = 248 - 8 * (int'(w.addr) % 32);
               idx = lookup_index(w.addr);
               table_byte = colour_table[idx % PROM_DEPTH];
               // register 1 picks the upper nibble on 8x16 machines
               if (cfg_variant != VARIANT_CELL16 && colour_reg[CREG_1] != 0) begin
                  pen = table_byte[7:4];
               end else begin
                  pen = table_byte[3:0];
               end
               fixed_coord = sx;
               if (cfg_swap ? !cfg_mirror_x : cfg_mirror_x) fixed_coord = (192 - sx) & 255;
               walk_up = cfg_swap ? cfg_mirror_y : !cfg_mirror_y;
               walk_start = walk_up ? sy : 255 - sy;
               for (int i = 0; i < 8; i++) begin
                  walk = (walk_up ? walk_start + i : walk_start - i) & 255;
                  lit = w.value[i];
                  px.row  = cfg_swap ? 8'(fixed_coord) : 8'(walk);
                  px.col  = cfg_swap ? 8'(walk) : 8'(fixed_coord);
                  px.pen  = lit ? pen : 4'd0;
                  px.lit  = lit;
                  px.last = (i == 7);
                  pending_pixels.push_back(px);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic queue_beat(input cpu_write_type w);
      apply_cpu_write(w);
      cpu_writes.push_back(w);
      issued_count++;
   endtask

   task automatic push_write(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [VAL_W-1:0] value);
      cpu_write_type w;
      int            idx;
      // a changed video byte reads one prom entry; load it first while still blank,
      // with junk upper address bits that the index fold must drop
      if (op == OP_VIDEO && int'(addr) < VIDEO_DEPTH && video_shadow[addr] != value) begin
         idx = lookup_index(addr) % PROM_DEPTH;
         if (!prom_loaded[idx]) begin
            w.op    = OP_PROM;
            w.addr  = ADDR_W'(idx + PROM_DEPTH * int'($urandom_range(0, 7)));
            w.value = VAL_W'($urandom);
            queue_beat(w);
         end
      end
      w.op    = op;
      w.addr  = addr;
      w.value = value;
      queue_beat(w);
   endtask

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // settings change only while the plotter is idle
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_VARIANT:  cfg_variant  = data;
         CSR_SWAP:     cfg_swap     = data[0];
         CSR_MIRROR_X: cfg_mirror_x = data[0];
         CSR_MIRROR_Y: cfg_mirror_y = data[0];
         default: ;
      endcase
   endtask

   // random traffic; ignored operation-3 beats are sprinkled in but not counted
   task automatic queue_random_writes(input int count);
      int          done_count;
      int          pick;
      logic [12:0] addr;
      logic [7:0]  value;
      logic [12:0] last_addr;
      logic [7:0]  last_value;
      bit          have_video;
      done_count = 0;
      have_video = 1'b0;
      last_addr  = '0;
      last_value = '0;
      while (done_count < count) begin
         pick  = $urandom_range(0, 99);
         addr  = 13'($urandom);
         value = 8'($urandom);
         if (pick < 8 && have_video) begin
            // same byte again, so nothing is plotted
            push_write(OP_VIDEO, last_addr, last_value);
            done_count++;
         end else if (pick < 60) begin
            // steer some writes into the 16x16 special band
            if ($urandom_range(0, 7) == 0) addr[4:0] = 5'd28;
            push_write(OP_VIDEO, addr, value);
            last_addr  = addr;
            last_value = value;
            have_video = 1'b1;
            done_count++;
         end else if (pick < 75) begin
            if ($urandom_range(0, 9) < 7) addr = 13'($urandom_range(0, 2));
            // 0 and 1 are the values the base and nibble rules care about
            case ($urandom_range(0, 3))
               0: value = 8'd0;
               1: value = 8'd1;
               default: ;
            endcase
            push_write(OP_COLOUR, addr, value);
            done_count++;
         end else if (pick < 92) begin
            push_write(OP_PROM, addr, value);
            done_count++;
         end else begin
            push_write(OP_NONE, addr, value);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // request driver: a beat stays up until taken, then an optional gap
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (!req_tvalid || req_took) begin
         if (send_gap > 0) begin
            req_tvalid <= 1'b0;
            send_gap = send_gap - 1;
         end else if (cpu_writes.size() > 0) begin
            next_write = cpu_writes.pop_front();
            req_tuser  <= next_write.op;
            req_tdata  <= {3'b000, next_write.value, next_write.addr};
            req_tvalid <= 1'b1;
            send_gap = steady_flow ? 0 : pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: ready for one cycle, then maybe a stall
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = steady_flow ? 0 : pick_gap();
      end
   end

   // ---------------------------------------------------------------------
   // monitor: count accepted cpu beats, check each pixel beat
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      req_took = req_tvalid && req_tready;
      rsp_took = rsp_tvalid && rsp_tready;
      if (!reset) begin
         if (req_took) begin
            accepted_count++;
         end
         if (rsp_took) begin
            got_pixel.row  = rsp_tdata[7:0];
            got_pixel.col  = rsp_tdata[15:8];
            got_pixel.pen  = rsp_tdata[19:16];
            got_pixel.lit  = rsp_tdata[20];
            got_pixel.last = rsp_tlast;
            if (pending_pixels.size() == 0) begin
               $display("%0t: unexpected pixel beat, expected none, got row %0d col %0d",
                        $time, got_pixel.row, got_pixel.col,
                        " pen %0d lit %0d last %0d",
                        got_pixel.pen, got_pixel.lit, got_pixel.last);
               error_count++;
            end else begin
               want_pixel = pending_pixels.pop_front();
               if (got_pixel.row !== want_pixel.row || got_pixel.col !== want_pixel.col
                   || got_pixel.pen !== want_pixel.pen || got_pixel.lit !== want_pixel.lit
                   || got_pixel.last !== want_pixel.last) begin
                  $display("%0t: pixel mismatch, expected row %0d col %0d pen %0d",
                           $time, want_pixel.row, want_pixel.col, want_pixel.pen,
                           " lit %0d last %0d,", want_pixel.lit, want_pixel.last,
                           " got row %0d col %0d pen %0d", got_pixel.row,
                           got_pixel.col, got_pixel.pen,
                           " lit %0d last %0d", got_pixel.lit, got_pixel.last);
                  error_count++;
               end
            end
         end
         // watchdog: a long run of cycles with no beat on either side
         if (req_took || rsp_took) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus: one phase per setting, every swap/mirror combination once
   // ---------------------------------------------------------------------
   initial begin
      logic [1:0] variant;
      for (int i = 0; i < VIDEO_DEPTH; i++) video_shadow[i] = '0;
      for (int i = 0; i < PROM_DEPTH; i++) colour_table[i] = '0;
      for (int i = 0; i < NUM_CREGS; i++) colour_reg[i] = '0;
      colour_base  = '0;
      cfg_variant  = VARIANT_NIBBLE;
      cfg_swap     = 1'b0;
      cfg_mirror_x = 1'b0;
      cfg_mirror_y = 1'b0;

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      // the video store sweep must finish first
      @(negedge clock);
      while (req_tready !== 1'b1) @(negedge clock);

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0, 6:    variant = VARIANT_NIBBLE;
            1, 4:    variant = VARIANT_CELL16;
            3:       variant = VARIANT_ZERO;
            default: variant = VARIANT_BANK;
         endcase
         steady_flow = (phase == 2 || phase == 5);
         write_register(CSR_VARIANT, variant);
         write_register(CSR_SWAP, {1'b0, phase[2]});
         write_register(CSR_MIRROR_X, {1'b0, phase[1]});
         write_register(CSR_MIRROR_Y, {1'b0, phase[0]});

         if (phase == 0) begin
            push_write(OP_VIDEO, 13'd0, 8'hFF);        // first strip, all lit
            push_write(OP_VIDEO, 13'h1FFF, 8'h80);     // last offset, top bit only
            push_write(OP_VIDEO, 13'h1FFF, 8'h80);     // unchanged byte
            push_write(OP_VIDEO, 13'd100, 8'h00);      // zero onto a cleared entry
            push_write(OP_COLOUR, 13'h1FFF, 8'h01);    // any number hits register 1 here
            push_write(OP_VIDEO, 13'd28, 8'h55);       // row 24 band, upper nibble
            push_write(OP_VIDEO, 13'h1FFF, 8'h7F);
            push_write(OP_PROM, 13'h1FFF, 8'hC3);      // wraps onto the last entry
            push_write(OP_COLOUR, 13'd1, 8'h00);       // back to the lower nibble
            push_write(OP_VIDEO, 13'd0, 8'h00);        // changed to all unlit
            push_write(OP_NONE, 13'h1FFF, 8'hFF);      // ignored operation
            push_write(OP_VIDEO, 13'd6176, 8'hA5);     // column past 192
            push_write(OP_NONE, 13'd0, 8'h00);
            push_write(OP_PROM, 13'd0, 8'hFF);
            push_write(OP_VIDEO, 13'd31, 8'h01);       // bottom of the screen
            push_write(OP_VIDEO, 13'd8160, 8'hFF);     // rightmost column, top strip
            push_write(OP_COLOUR, 13'd2, 8'hFF);
            push_write(OP_VIDEO, 13'd8160, 8'h0F);
            queue_random_writes(24);
         end else begin
            queue_random_writes(36);
         end

         // drain before the next settings change
         while (accepted_count != issued_count || pending_pixels.size() != 0)
            @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
      end

      if (pending_pixels.size() != 0) begin
         $display("%0t: %0d expected pixel beats never arrived", $time,
                  pending_pixels.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: bitmap_video_colour_plotter.f
+incdir+rtl
rtl/bvcp_pkg.sv
rtl/bvcp_ram.sv
rtl/bvcp_datapath.sv
rtl/bvcp_ctrl.sv
rtl/bitmap_video_colour_plotter.sv
sim/tb_top.sv
